### hdl/swm_pkg.sv
package swm_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;
    localparam int LEN_W    = 7;

    // defaults
    localparam int WINDOW_MAX_DEF   = 64;
    localparam int WINDOW_LEN_RESET = 3;

endpackage

### hdl/swm_ram.sv
module swm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/sliding_window_median_core.sv
// Running median filter over the last window_len signed 32-bit samples
// (window_len 1..WINDOW_MAX; 0 acts as 1, larger values saturate). Each item
// carries a sample and a restart flag that empties the window first. Once the
// window is full every item yields one result, twice the median, so even
// windows come out exact with one fractional bit. Writing window_len also
// empties the window. Samples are held twice: in an arrival ring and in a
// sorted store, each with one write port and one registered read port. One
// item is worked on at a time and s_ready is low meanwhile: while filling, an
// item walks down the sorted store from its end to its sorted position; with a
// full window the removal of the oldest sample first scans the whole sorted
// store, a read state and a data state per entry, and the insertion then
// walks down it the same way, before the middle entry (two for an even
// window) is read for the result. The sorted store's single read and single
// write port, with its registered read, sets this pace. A finished result
// waits in the output register while the next item is accepted; a new result
// then waits until that one has been taken.
module sliding_window_median_core #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [swm_pkg::SAMPLE_W-1:0]  s_sample,
    input  logic                                 s_restart,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [swm_pkg::MEDIAN_W-1:0]  m_median_x2,
    input  logic                                 cfg_we,
    input  logic        [swm_pkg::LEN_W-1:0]     cfg_wdata
);

    import swm_pkg::*;

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int EW = (CW > LEN_W) ? CW : LEN_W;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_RING     = 10'b0000000010,
        S_RM_ADDR  = 10'b0000000100,
        S_RM_DATA  = 10'b0000001000,
        S_INS      = 10'b0000010000,
        S_INS_DATA = 10'b0000100000,
        S_FIN      = 10'b0001000000,
        S_MED_HI   = 10'b0010000000,
        S_MED_LO   = 10'b0100000000,
        S_OUT      = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [LEN_W-1:0]           win_len_reg, win_len_next;
    logic [CW-1:0]              fill_reg, fill_next;
    logic [AW-1:0]              ptr_reg, ptr_next;
    logic [AW-1:0]              slot_reg, slot_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic                       found_reg, found_next;
    logic signed [SAMPLE_W-1:0] v_reg, v_next;
    logic signed [SAMPLE_W-1:0] old_reg, old_next;
    logic signed [SAMPLE_W-1:0] hi_reg, hi_next;
    logic signed [MEDIAN_W-1:0] acc_reg, acc_next;
    logic                       m_valid_reg, m_valid_next;
    logic signed [MEDIAN_W-1:0] m_data_reg, m_data_next;

    // memory ports
    logic                ring_we, ring_re;
    logic [AW-1:0]       ring_waddr, ring_raddr;
    logic [SAMPLE_W-1:0] ring_wdata, ring_rdata;
    logic                srt_we, srt_re;
    logic [AW-1:0]       srt_waddr, srt_raddr;
    logic [SAMPLE_W-1:0] srt_wdata, srt_rdata;

    // effective window length
    logic [EW-1:0] wl_ext;
    logic [CW-1:0] len_eff;
    logic [CW-1:0] len_half;
    logic [AW-1:0] half_addr;

    assign wl_ext = EW'(win_len_reg);

    always_comb begin
        if (wl_ext == '0) begin
            len_eff = CW'(1);
        end else if (wl_ext > EW'(WINDOW_MAX)) begin
            len_eff = CW'(WINDOW_MAX);
        end else begin
            len_eff = wl_ext[CW-1:0];
        end
    end

    assign len_half  = len_eff >> 1;
    assign half_addr = len_half[AW-1:0];

    // accept-time view of the window after an optional restart
    logic [CW-1:0] fill_eff;
    logic [AW-1:0] ptr_eff;
    logic [CW:0]   slot_sum;
    logic [CW:0]   slot_wrap;
    logic [CW-1:0] slot_inc;
    logic [CW-1:0] idx_dec;
    logic [CW-1:0] fill_inc;
    logic [CW-1:0] len_dec;

    assign fill_eff  = s_restart ? '0 : fill_reg;
    assign ptr_eff   = s_restart ? '0 : ptr_reg;
    assign slot_sum  = (CW+1)'(ptr_eff) + (CW+1)'(fill_eff);
    assign slot_wrap = (slot_sum >= (CW+1)'(len_eff)) ? slot_sum - (CW+1)'(len_eff)
                                                      : slot_sum;
    assign slot_inc  = CW'(slot_reg) + CW'(1);
    assign idx_dec   = idx_reg - CW'(1);
    assign fill_inc  = fill_reg + CW'(1);
    assign len_dec   = len_eff - CW'(1);

    // shared compare unit
    logic signed [SAMPLE_W-1:0] cmp_a, cmp_b;
    logic                       cmp_eq, cmp_gt;

    assign cmp_a  = srt_rdata;
    assign cmp_b  = (state_reg == S_RM_DATA) ? old_reg : v_reg;
    assign cmp_eq = (cmp_a == cmp_b);
    assign cmp_gt = (cmp_a > cmp_b);

    // shared adder for the median
    logic signed [MEDIAN_W-1:0] add_a, add_b, add_sum;

    assign add_a   = MEDIAN_W'(cmp_a);
    assign add_b   = (state_reg == S_MED_HI) ? MEDIAN_W'(cmp_a) : MEDIAN_W'(hi_reg);
    assign add_sum = add_a + add_b;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        win_len_next = win_len_reg;
        fill_next    = fill_reg;
        ptr_next     = ptr_reg;
        slot_next    = slot_reg;
        idx_next     = idx_reg;
        found_next   = found_reg;
        v_next       = v_reg;
        old_next     = old_reg;
        hi_next      = hi_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_data_next  = m_data_reg;
        ring_we      = 1'b0;
        ring_waddr   = slot_reg;
        ring_wdata   = v_reg;
        ring_re      = 1'b0;
        ring_raddr   = ptr_eff;
        srt_we       = 1'b0;
        srt_waddr    = idx_reg[AW-1:0];
        srt_wdata    = v_reg;
        srt_re       = 1'b0;
        srt_raddr    = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    v_next    = s_sample;
                    fill_next = fill_eff;
                    ptr_next  = ptr_eff;
                    if (fill_eff >= len_eff) begin
                        // full: fetch the oldest sample first
                        ring_re    = 1'b1;
                        ring_raddr = ptr_eff;
                        slot_next  = ptr_eff;
                        state_next = S_RING;
                    end else begin
                        ring_we    = 1'b1;
                        ring_waddr = slot_wrap[AW-1:0];
                        ring_wdata = s_sample;
                        idx_next   = fill_eff;
                        state_next = S_INS;
                    end
                end
            end
            S_RING: begin
                old_next   = ring_rdata;
                ring_we    = 1'b1;
                ptr_next   = (slot_inc == len_eff) ? '0 : slot_inc[AW-1:0];
                idx_next   = '0;
                found_next = 1'b0;
                state_next = S_RM_ADDR;
            end
            S_RM_ADDR: begin
                if (idx_reg == fill_reg) begin
                    fill_next  = len_dec;
                    idx_next   = len_dec;
                    state_next = S_INS;
                end else begin
                    srt_re     = 1'b1;
                    state_next = S_RM_DATA;
                end
            end
            S_RM_DATA: begin
                // after the match, every entry moves down one place
                if (found_reg) begin
                    srt_we    = 1'b1;
                    srt_waddr = idx_dec[AW-1:0];
                    srt_wdata = srt_rdata;
                end else if (cmp_eq) begin
                    found_next = 1'b1;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = S_RM_ADDR;
            end
            S_INS: begin
                if (idx_reg == '0) begin
                    srt_we     = 1'b1;
                    state_next = S_FIN;
                end else begin
                    srt_re     = 1'b1;
                    srt_raddr  = idx_dec[AW-1:0];
                    state_next = S_INS_DATA;
                end
            end
            S_INS_DATA: begin
                srt_we = 1'b1;
                if (cmp_gt) begin
                    srt_wdata  = srt_rdata;
                    idx_next   = idx_dec;
                    state_next = S_INS;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                fill_next = fill_inc;
                if (fill_inc < len_eff) begin
                    state_next = S_IDLE;
                end else begin
                    srt_re     = 1'b1;
                    srt_raddr  = half_addr;
                    state_next = S_MED_HI;
                end
            end
            S_MED_HI: begin
                hi_next = srt_rdata;
                if (len_eff[0]) begin
                    acc_next   = add_sum;
                    state_next = S_OUT;
                end else begin
                    srt_re     = 1'b1;
                    srt_raddr  = half_addr - AW'(1);
                    state_next = S_MED_LO;
                end
            end
            S_MED_LO: begin
                acc_next   = add_sum;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = acc_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // register write empties the window
        if (cfg_we) begin
            win_len_next = cfg_wdata;
            fill_next    = '0;
            ptr_next     = '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            win_len_reg <= LEN_W'(WINDOW_LEN_RESET);
            fill_reg    <= '0;
            ptr_reg     <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            win_len_reg <= win_len_next;
            fill_reg    <= fill_next;
            ptr_reg     <= ptr_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        slot_reg   <= slot_next;
        idx_reg    <= idx_next;
        v_reg      <= v_next;
        old_reg    <= old_next;
        hi_reg     <= hi_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    // arrival ring
    swm_ram #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (SAMPLE_W),
        .AW    (AW)
    ) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // sorted store
    swm_ram #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (SAMPLE_W),
        .AW    (AW)
    ) u_sorted (
        .aclk  (aclk),
        .we    (srt_we),
        .waddr (srt_waddr),
        .wdata (srt_wdata),
        .re    (srt_re),
        .raddr (srt_raddr),
        .rdata (srt_rdata)
    );

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_median_x2 = m_data_reg;

endmodule

### verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import swm_pkg::*;

    localparam int          DEPTH       = swm_pkg::WINDOW_MAX_DEF;
    // margin for the worst item with a full window, which holds s_ready low
    localparam int          SETTLE_CYC  = 4 * DEPTH + 40;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          N_PHASES    = 10;

    // window lengths for the random phases, extremes and saturation included
    localparam logic [LEN_W-1:0] PHASE_LEN [N_PHASES] =
        '{7'd3, 7'd1, 7'd0, 7'd2, 7'd64, 7'd127, 7'd65, 7'd5, 7'd8, 7'd63};
    localparam int PHASE_ITEMS [N_PHASES] =
        '{100, 80, 60, 100, 190, 140, 70, 100, 100, 130};

    localparam logic [SAMPLE_W-1:0] SAMPLE_EDGES [4] =
        '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};

    // directed items at the reset length of 3: bit 32 is the restart flag
    localparam logic [SAMPLE_W:0] DIRECTED_ODD [18] = '{
        33'h0_8000_0000, 33'h0_7fff_ffff, 33'h0_0000_0000, 33'h0_8000_0000,
        33'h0_8000_0000, 33'h0_7fff_ffff, 33'h0_7fff_ffff, 33'h0_ffff_ffff,
        33'h0_0000_0001, 33'h1_0000_0005, 33'h0_0000_0005, 33'h0_0000_0005,
        33'h0_ffff_ffff, 33'h1_0000_0003, 33'h1_7fff_ffff, 33'h0_7fff_ffff,
        33'h0_7fff_ffff, 33'h0_8000_0000
    };
    // directed items at length 2: largest and smallest sums, odd sum
    localparam logic [SAMPLE_W:0] DIRECTED_EVEN [6] = '{
        33'h0_7fff_ffff, 33'h0_7fff_ffff, 33'h0_8000_0000, 33'h0_8000_0000,
        33'h0_0000_0001, 33'h0_ffff_fffe
    };

    // running median tracker: window state, pending medians and error count
    class median_tracker;
        logic [LEN_W-1:0]           len_reg = LEN_W'(WINDOW_LEN_RESET);
        logic signed [SAMPLE_W-1:0] ring [DEPTH];
        logic signed [SAMPLE_W-1:0] sorted_q [$];
        int unsigned                fill = 0;
        int unsigned                oldest = 0;
        logic signed [MEDIAN_W-1:0] medians_due [$];
        int                         errors = 0;
        int                         n_samples = 0;
        int                         n_restarts = 0;
        int                         n_medians = 0;
        int                         n_len_writes = 0;

        function int unsigned eff_len();
            if (len_reg == 0) return 1;
            if (len_reg > DEPTH) return DEPTH;
            return len_reg;
        endfunction

        // a length write also empties the window
        function void write_len(logic [LEN_W-1:0] v);
            len_reg = v;
            fill = 0;
            oldest = 0;
            sorted_q.delete();
            n_len_writes++;
        endfunction

        function void take_sample(logic signed [SAMPLE_W-1:0] smp, logic rst);
            int unsigned                L;
            int unsigned                slot;
            int unsigned                pos;
            logic signed [MEDIAN_W-1:0] lo;
            logic signed [MEDIAN_W-1:0] hi;
            L = eff_len();
            n_samples++;
            if (rst) begin
                fill = 0;
                oldest = 0;
                sorted_q.delete();
                n_restarts++;
            end
            // full window: drop one copy of the oldest value, reuse its slot
            if (fill >= L) begin
                slot = oldest % L;
                for (int i = 0; i < sorted_q.size(); i++) begin
                    if (sorted_q[i] == ring[slot]) begin
                        sorted_q.delete(i);
                        break;
                    end
                end
                fill = L - 1;
                ring[slot] = smp;
                oldest = (slot + 1) % L;
            end else begin
                slot = (oldest + fill) % L;
                ring[slot] = smp;
            end
            // ordered insert behind equal values
            pos = sorted_q.size();
            while (pos > 0 && sorted_q[pos-1] > smp) pos--;
            sorted_q.insert(pos, smp);
            fill++;
            if (fill < L) return;
            // twice the median, sign extended to the result width
            hi = sorted_q[L/2];
            lo = (L % 2) ? sorted_q[L/2] : sorted_q[L/2 - 1];
            medians_due.insert(medians_due.size(), lo + hi);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_median(logic signed [MEDIAN_W-1:0] got);
            logic signed [MEDIAN_W-1:0] want;
            if (medians_due.size() == 0) begin
                report_mismatch($sformatf("median_x2 %0d with none pending", got));
                return;
            end
            want = medians_due.pop_front();
            n_medians++;
            if (got !== want)
                report_mismatch($sformatf("median_x2 got %0d expected %0d (result %0d)",
                                          got, want, n_medians));
        endtask
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample = '0;
    logic                       s_restart = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [MEDIAN_W-1:0] m_median_x2;
    logic                       cfg_we = 1'b0;
    logic [LEN_W-1:0]           cfg_wdata = '0;

    median_tracker              sb = new();
    int                         send_idle_pct = 10;
    int                         recv_idle_pct = 69;
    int unsigned                cycle_count = 0;

    sliding_window_median_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_median_x2 (m_median_x2),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d medians pending",
                     cycle_count, sb.medians_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: check accepted items, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_median(m_median_x2);
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // offer one item, return at the edge that accepts it
    task automatic send_item(input logic signed [SAMPLE_W-1:0] smp, input logic rst);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_sample  <= smp;
        s_restart <= rst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.take_sample(smp, rst);
    endtask

    // wait for all pending medians, then for an item that made none
    task automatic settle_block();
        s_valid <= 1'b0;
        while (sb.medians_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_window_len(input logic [LEN_W-1:0] v);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.write_len(v);
        cfg_we    <= 1'b0;
    endtask

    // stimulus
    initial begin
        logic signed [SAMPLE_W-1:0] smp;
        logic signed [SAMPLE_W-1:0] last_smp;
        logic                       rst;
        int unsigned                win;
        last_smp = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, duplicates and restarts at the reset length
        foreach (DIRECTED_ODD[i])
            send_item(DIRECTED_ODD[i][SAMPLE_W-1:0], DIRECTED_ODD[i][SAMPLE_W]);
        write_window_len(7'd2);
        foreach (DIRECTED_EVEN[i])
            send_item(DIRECTED_EVEN[i][SAMPLE_W-1:0], DIRECTED_EVEN[i][SAMPLE_W]);

        // random phases over a range of window lengths
        for (int p = 0; p < N_PHASES; p++) begin
            if (p < 4) begin
                send_idle_pct = 10;
                recv_idle_pct = 69;
            end else if (p < 7) begin
                send_idle_pct = 69;
                recv_idle_pct = 10;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_window_len(PHASE_LEN[p]);
            win = sb.eff_len();
            for (int k = 0; k < PHASE_ITEMS[p]; k++) begin
                // mix of wide values, small values with many ties, and edges
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: smp = $urandom;
                    4, 5, 6:    smp = int'($urandom_range(0, 16)) - 8;
                    7:          smp = SAMPLE_EDGES[$urandom_range(0, 3)];
                    8:          smp = $urandom_range(0, 1) ?
                                      32'h7fff_ffff - $urandom_range(0, 3) :
                                      32'h8000_0000 + $urandom_range(0, 3);
                    default:    smp = last_smp;
                endcase
                // rare restarts so most sequences fill the window
                rst = ($urandom_range(0, 3 * win + 12) == 0);
                send_item(smp, rst);
                last_smp = smp;
            end
        end

        settle_block();
        $display("covered %0d samples with %0d restarts and %0d window length writes",
                 sb.n_samples, sb.n_restarts, sb.n_len_writes);
        $display("checked %0d medians over lengths 0 to 127, %0d mismatches",
                 sb.n_medians, sb.errors);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
hdl/swm_pkg.sv
hdl/swm_ram.sv
hdl/sliding_window_median_core.sv
verif/tb_top.sv
